### hw/rtl/utf8d_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 stream decoder.
`default_nettype none

package utf8d_pkg;

	localparam int INDEX_BITS = 16;

	localparam logic [15:0] IDX_LIMIT = (INDEX_BITS >= 16) ? 16'hFFFF :
		16'((33'd1 << INDEX_BITS) - 33'd1);

	localparam logic [7:0]  BOM_BYTE0 = 8'hEF;
	localparam logic [7:0]  BOM_BYTE1 = 8'hBB;
	localparam logic [7:0]  BOM_BYTE2 = 8'hBF;
	localparam logic [20:0] CP_MAX    = 21'h10FFFF;

	localparam int          PADDR_BITS   = 3;
	localparam logic [0:0]  REG_SKIP_BOM = 1'b0;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LEAD  = 2'd1,
		ST_TOO_BIG   = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_of_string;
		logic       last_of_string;
	} utf8d_byte_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  seq_length;
		logic [15:0] char_index;
		logic [1:0]  status;
		logic        end_of_string;
	} utf8d_char_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		begin
			len = 3'd0;
			if (b <= 8'h7F) begin
				len = 3'd1;
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				len = 3'd2;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				len = 3'd3;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				len = 3'd4;
			end
			return len;
		end
	endfunction

	function automatic logic [7:0] lead_mask(input logic [2:0] len);
		logic [7:0] m;
		begin
			m = 8'h07;
			if (len == 3'd2) begin
				m = 8'h1F;
			end else if (len == 3'd3) begin
				m = 8'h0F;
			end
			return m;
		end
	endfunction

endpackage

`default_nettype wire

### hw/rtl/utf8d_if.sv
// Word channel interfaces for the byte input and the code point output.
`default_nettype none

interface utf8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       first_of_string;
	logic       last_of_string;

	modport source (output valid, output in_byte, output first_of_string,
		output last_of_string, input ready);
	modport sink (input valid, input in_byte, input first_of_string,
		input last_of_string, output ready);
endinterface

interface utf8d_char_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [2:0]  seq_length;
	logic [15:0] char_index;
	logic [1:0]  status;
	logic        end_of_string;

	modport source (output valid, output code_point, output seq_length,
		output char_index, output status, output end_of_string, input ready);
	modport sink (input valid, input code_point, input seq_length,
		input char_index, input status, input end_of_string, output ready);
endinterface

`default_nettype wire

### hw/rtl/utf8d_step.sv
// Decoder state and the combinational decode of one registered byte.
`default_nettype none

module utf8d_step
	import utf8d_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire utf8d_byte_t item,
	input  wire logic        skip_bom,
	output logic             has_result,
	output utf8d_char_t      result
);

	logic [20:0] partial_q;
	logic [1:0]  left_q;
	logic [2:0]  seq_len_q;
	logic        bom_q;
	logic [15:0] count_q;
	logic        failed_q;

	logic [20:0] pc, n_pc, joined;
	logic [1:0]  bl, n_bl, bl_dec;
	logic [2:0]  sl, n_sl, len, pos;
	logic        bc, n_bc, bc_dec;
	logic [15:0] cc, n_cc, cc_bump;
	logic        sf, n_sf;
	logic [7:0]  want;

	always_comb begin
		pc = item.first_of_string ? '0 : partial_q;
		bl = item.first_of_string ? '0 : left_q;
		sl = item.first_of_string ? '0 : seq_len_q;
		bc = item.first_of_string ? 1'b0 : bom_q;
		cc = item.first_of_string ? '0 : count_q;
		sf = item.first_of_string ? 1'b0 : failed_q;

		cc_bump = (cc < IDX_LIMIT) ? cc + 16'd1 : cc;
		len     = lead_length(item.in_byte);
		joined  = {pc[14:0], item.in_byte[5:0]};
		pos     = sl - {1'b0, bl};
		want    = (pos == 3'd1) ? BOM_BYTE1 : BOM_BYTE2;
		bc_dec  = bc && (item.in_byte == want);
		bl_dec  = bl - 2'd1;

		n_pc = pc;
		n_bl = bl;
		n_sl = sl;
		n_bc = bc;
		n_cc = cc;
		n_sf = sf;

		has_result              = 1'b0;
		result.code_point       = '0;
		result.seq_length       = '0;
		result.char_index       = cc;
		result.status           = ST_OK;
		result.end_of_string    = item.last_of_string;

		if (!sf) begin
			if (bl == 2'd0) begin
				if (len == 3'd0) begin
					has_result    = 1'b1;
					result.status = ST_BAD_LEAD;
					n_sf          = 1'b1;
				end else if (len == 3'd1) begin
					has_result        = 1'b1;
					result.code_point = {13'd0, item.in_byte};
					result.seq_length = 3'd1;
					n_cc              = cc_bump;
				end else if (item.last_of_string) begin
					has_result    = 1'b1;
					result.status = ST_TRUNCATED;
					n_pc          = '0;
					n_bl          = '0;
					n_sl          = '0;
					n_bc          = 1'b0;
					n_sf          = 1'b1;
				end else begin
					n_pc = {13'd0, item.in_byte & lead_mask(len)};
					n_bl = 2'(len - 3'd1);
					n_sl = len;
					n_bc = item.first_of_string && skip_bom && (item.in_byte == BOM_BYTE0);
				end
			end else begin
				if (bl_dec == 2'd0) begin
					n_pc = '0;
					n_bl = '0;
					n_sl = '0;
					n_bc = 1'b0;
					if (!bc_dec) begin
						has_result = 1'b1;
						if (joined > CP_MAX) begin
							result.status = ST_TOO_BIG;
							n_sf          = 1'b1;
						end else begin
							result.code_point = joined;
							result.seq_length = sl;
							n_cc              = cc_bump;
						end
					end
				end else if (item.last_of_string) begin
					has_result    = 1'b1;
					result.status = ST_TRUNCATED;
					n_pc          = '0;
					n_bl          = '0;
					n_sl          = '0;
					n_bc          = 1'b0;
					n_sf          = 1'b1;
				end else begin
					n_pc = joined;
					n_bl = bl_dec;
					n_bc = bc_dec;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			left_q    <= '0;
			seq_len_q <= '0;
			bom_q     <= 1'b0;
			count_q   <= '0;
			failed_q  <= 1'b0;
		end else if (advance) begin
			partial_q <= n_pc;
			left_q    <= n_bl;
			seq_len_q <= n_sl;
			bom_q     <= n_bc;
			count_q   <= n_cc;
			failed_q  <= n_sf;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/utf8_stream_decoder.sv
// Top level: input register, decode step, result register and register port.
// A byte is taken into the input register, decoded combinationally, and its result word is registered.
// Throughput: one byte per cycle while the result register is free or the byte yields no word.
// A stalled result register holds its word while the next byte is decoded.
// Reset clears all valid flags and decode state and sets skip_bom to one.
`default_nettype none

module utf8_stream_decoder
	import utf8d_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	utf8d_byte_if.sink                 text,
	utf8d_char_if.source               chars
);

	logic        skip_bom_q;
	logic        valid_s1;
	utf8d_byte_t item_s1;
	logic        out_valid_q;
	utf8d_char_t result_q;
	logic        has_result;
	utf8d_char_t result;
	logic        out_free;
	logic        advance;
	logic        reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_BITS-1:2] == REG_SKIP_BOM);
	assign prdata  = reg_hit ? {31'd0, skip_bom_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_bom_q <= 1'b1;
		end else if (psel && penable && pwrite && reg_hit) begin
			skip_bom_q <= pwdata[0];
		end
	end

	assign out_free   = !out_valid_q || chars.ready;
	assign advance    = valid_s1 && (!has_result || out_free);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1.in_byte         <= text.in_byte;
			item_s1.first_of_string <= text.first_of_string;
			item_s1.last_of_string  <= text.last_of_string;
		end
	end

	utf8d_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.skip_bom   (skip_bom_q),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= result;
		end
	end

	assign chars.valid         = out_valid_q;
	assign chars.code_point    = result_q.code_point;
	assign chars.seq_length    = result_q.seq_length;
	assign chars.char_index    = result_q.char_index;
	assign chars.status        = result_q.status;
	assign chars.end_of_string = result_q.end_of_string;

endmodule

`default_nettype wire

### hw/rtl/utf8d_checker.sv
// Port-level checks on the decoder output, bound to the top level.
`default_nettype none

module utf8d_checker
	import utf8d_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [20:0] code_point,
	input wire logic [2:0]  seq_length,
	input wire logic [1:0]  status,
	input wire logic        end_of_string
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(code_point) && $stable(status))
		else $error("Output word changed while stalled.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status != ST_OK) |-> (code_point == 21'd0) && (seq_length == 3'd0))
		else $error("Error word carries a code point or length.");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status == ST_OK) |-> (seq_length != 3'd0) && (seq_length <= 3'd4)
			&& (code_point <= CP_MAX))
		else $error("Good word has a bad length or code point.");

	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status == ST_OK) && (seq_length == 3'd1) |-> (code_point < 21'h80))
		else $error("Single-byte word above the ASCII range.");

	a_trunc_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status == ST_TRUNCATED) |-> end_of_string)
		else $error("Truncation reported before the end of the string.");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (chars.valid),
	.ready         (chars.ready),
	.code_point    (chars.code_point),
	.seq_length    (chars.seq_length),
	.status        (chars.status),
	.end_of_string (chars.end_of_string)
);

`default_nettype wire
